// ===== rtl/qai_pkg.sv =====
// shared constants and types for the quaternion attitude integrator
package qai_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 64;
  localparam logic [31:0] TimeStepReset = 32'd4294967;
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  // multiplier operand selection codes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_NEG = 2'd1
  } op_e;
endpackage

// ===== rtl/qai_mul.sv =====
// bit-serial signed 32x32 multiplier, one multiplier bit per cycle
module qai_mul import qai_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] a_i,
  input  logic signed [DataW-1:0] b_i,
  output logic                    done_o,
  output logic signed [ProdW-1:0] p_o
);
  logic [5:0]              cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic signed [ProdW-1:0] acc_q, acc_d;
  logic signed [ProdW-1:0] mc_q, mc_d;
  logic [DataW-1:0]        mp_q, mp_d;
  logic                    done_q, done_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      mc_d   = ProdW'(a_i);
      mp_d   = b_i;
    end else if (busy_q) begin
      // top multiplier bit has negative weight
      if (mp_q[0]) begin
        if (cnt_q == 6'(DataW - 1)) acc_d = acc_q - mc_q;
        else acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== rtl/qai_sqrt.sv =====
// digit-serial integer square root, one result bit per cycle
module qai_sqrt import qai_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] n_i,
  output logic             done_o,
  output logic [DataW-1:0] root_o
);
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [ProdW-1:0] rad_q, rad_d;
  logic [DataW+1:0] rem_q, rem_d;
  logic [DataW-1:0] root_q, root_d;
  logic             done_q, done_d;
  logic [DataW+1:0] trial;
  logic [DataW+1:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    done_d  = 1'b0;
    shifted = {rem_q[DataW-1:0], rad_q[ProdW-1:ProdW-2]};
    trial   = {root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = n_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[DataW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== rtl/qai_div.sv =====
// bit-serial restoring divider, 63-bit dividend by 32-bit divisor
module qai_div import qai_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [62:0]      num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [62:0]      quo_o
);
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [62:0]      quo_q, quo_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] den_q, den_d;
  logic             done_q, done_d;
  logic [DataW:0]   sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    sh     = {rem_q[DataW-1:0], quo_q[62]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[61:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[61:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd62) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/quaternion_attitude_integrator.sv =====
// top level: sequencer around a shared serial multiplier, square root and divider
// An item is accepted in S_IDLE and passes through S_HALF, S_TERM, S_SQR, S_ROOT,
// S_DIV and S_OUT. Nineteen products (three rate-by-step, twelve quaternion terms,
// four squares) run on one bit-serial multiplier. The square root follows, then
// four divisions on one serial divider, and S_OUT loads the output register. A zero
// norm skips the root and the divisions. The next item is accepted in S_IDLE, which
// follows the loading of a result, so a new item is taken only once the last result
// is in the output register. A stalled result holds only the next result back from
// the output register. The attitude starts at identity after reset.
module quaternion_attitude_integrator import qai_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // rate_x, rate_y, rate_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata, // att_w, att_x, att_y, att_z
  output logic        m_axis_tuser,  // degenerate
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HALF = 7'b0000010,
    S_TERM = 7'b0000100,
    S_SQR  = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] tstep_q;
  logic signed [31:0] att_q [4];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] h_q [3];
  logic signed [33:0] d_q [4];
  logic signed [31:0] qn_q [4];
  logic [63:0] n2_q;
  logic [31:0] nrm_q;
  logic [3:0] idx_q;
  logic mstart, sstart, dstart;
  logic mdone, sdone, ddone;
  logic signed [63:0] prod;
  logic [31:0] root;
  logic [62:0] quo;
  logic signed [31:0] ma, mb;
  logic [62:0] dnum;
  logic [1:0] ta, tb, td;
  logic tneg;
  logic out_valid_q;
  logic [127:0] out_data_q;
  logic out_deg_q;
  logic out_fire;
  logic signed [64:0] hr;
  logic signed [63:0] tr;
  logic [31:0] mag;
  logic [32:0] qv;

  qai_mul u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
                 .done_o(mdone), .p_o(prod));
  qai_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sstart), .n_i(n2_q),
                   .done_o(sdone), .root_o(root));
  qai_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(nrm_q),
                 .done_o(ddone), .quo_o(quo));

  // term table: index -> (q index, h index, dest, negate)
  always_comb begin
    ta = 2'd0; tb = 2'd0; td = 2'd0; tneg = 1'b0;
    unique case (idx_q)
      4'd0:  begin ta = 2'd1; tb = 2'd0; td = 2'd0; tneg = 1'b1; end
      4'd1:  begin ta = 2'd2; tb = 2'd1; td = 2'd0; tneg = 1'b1; end
      4'd2:  begin ta = 2'd3; tb = 2'd2; td = 2'd0; tneg = 1'b1; end
      4'd3:  begin ta = 2'd0; tb = 2'd0; td = 2'd1; end
      4'd4:  begin ta = 2'd2; tb = 2'd2; td = 2'd1; end
      4'd5:  begin ta = 2'd3; tb = 2'd1; td = 2'd1; tneg = 1'b1; end
      4'd6:  begin ta = 2'd0; tb = 2'd1; td = 2'd2; end
      4'd7:  begin ta = 2'd3; tb = 2'd0; td = 2'd2; end
      4'd8:  begin ta = 2'd1; tb = 2'd2; td = 2'd2; tneg = 1'b1; end
      4'd9:  begin ta = 2'd0; tb = 2'd2; td = 2'd3; end
      4'd10: begin ta = 2'd1; tb = 2'd1; td = 2'd3; end
      4'd11: begin ta = 2'd2; tb = 2'd0; td = 2'd3; tneg = 1'b1; end
      default: begin ta = 2'd0; tb = 2'd0; td = 2'd0; tneg = 1'b0; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_HALF: begin ma = rate_q[idx_q[1:0]]; mb = $signed(tstep_q); end
      S_TERM: begin ma = att_q[ta]; mb = h_q[tb]; end
      S_SQR:  begin ma = qn_q[idx_q[1:0]]; mb = qn_q[idx_q[1:0]]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // unsigned step: fix the signed product by adding rate<<32 when step msb set
  assign hr  = 65'(prod) + (tstep_q[31] ? (65'(rate_q[idx_q[1:0]]) <<< 32) : 65'sd0)
             + 65'sd262144;
  assign tr  = (prod + 64'sd536870912) >>> 30;
  assign mag = qn_q[idx_q[1:0]][31] ? 32'(-qn_q[idx_q[1:0]]) : qn_q[idx_q[1:0]];
  assign dnum = {mag[31:0], 30'd0} + 63'(nrm_q >> 1);
  assign qv = (quo > 63'h8000_0000) ? 33'h1_0000_0000 : quo[32:0];

  assign out_fire = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  logic started_q, started_d;
  always_comb begin
    state_d = state_q;
    started_d = started_q;
    mstart = 1'b0; sstart = 1'b0; dstart = 1'b0;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_HALF;
      S_HALF, S_TERM, S_SQR: begin
        if (!started_q) begin mstart = 1'b1; started_d = 1'b1; end
        else if (mdone) started_d = 1'b0;
        if (mdone && state_q == S_HALF && idx_q == 4'd2) state_d = S_TERM;
        if (mdone && state_q == S_TERM && idx_q == 4'd11) state_d = S_SQR;
        if (mdone && state_q == S_SQR && idx_q == 4'd3) state_d = S_ROOT;
      end
      S_ROOT: begin
        if (!started_q) begin
          if (n2_q == '0) state_d = S_OUT;
          else begin sstart = 1'b1; started_d = 1'b1; end
        end else if (sdone) begin started_d = 1'b0; state_d = S_DIV; end
      end
      S_DIV: begin
        if (!started_q) begin dstart = 1'b1; started_d = 1'b1; end
        else if (ddone) begin
          started_d = 1'b0;
          if (idx_q == 4'd3) state_d = S_OUT;
        end
      end
      S_OUT: if (out_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      started_q <= 1'b0;
      idx_q <= '0;
      tstep_q <= TimeStepReset;
      att_q[0] <= OneQ30; att_q[1] <= '0; att_q[2] <= '0; att_q[3] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      started_q <= started_d;
      if (cfg_we_i) tstep_q <= cfg_wdata_i;
      if (out_fire) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: idx_q <= '0;
        S_HALF: if (mdone) idx_q <= (idx_q == 4'd2) ? 4'd0 : idx_q + 4'd1;
        S_TERM: if (mdone) idx_q <= (idx_q == 4'd11) ? 4'd0 : idx_q + 4'd1;
        S_SQR: if (mdone) idx_q <= (idx_q == 4'd3) ? 4'd0 : idx_q + 4'd1;
        S_DIV: if (ddone) idx_q <= idx_q + 4'd1;
        S_OUT: begin
          if (out_fire) begin
            if (n2_q == '0) begin
              att_q[0] <= OneQ30; att_q[1] <= '0; att_q[2] <= '0; att_q[3] <= '0;
            end else begin
              for (int i = 0; i < 4; i++) att_q[i] <= qn_q[i];
            end
          end
        end
        default: idx_q <= '0;
      endcase
    end
  end

  logic signed [45:0] hq;
  logic signed [31:0] hsat;
  assign hq   = hr[64:19];
  assign hsat = (hq > 46'sd2147483647) ? 32'h7fff_ffff :
                (hq < -46'sd2147483648) ? 32'h8000_0000 : hq[31:0];

  logic signed [31:0] qsum [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qsum[i] = (35'(att_q[i]) + 35'(d_q[i]) > 35'sd2147483647) ? 32'h7fff_ffff :
                (35'(att_q[i]) + 35'(d_q[i]) < -35'sd2147483648) ? 32'h8000_0000 :
                32'(35'(att_q[i]) + 35'(d_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      rate_q[0] <= s_axis_tdata[31:0];
      rate_q[1] <= s_axis_tdata[63:32];
      rate_q[2] <= s_axis_tdata[95:64];
      for (int i = 0; i < 4; i++) d_q[i] <= '0;
      n2_q <= '0;
    end
    if (state_q == S_HALF && mdone) h_q[idx_q[1:0]] <= hsat;
    if (state_q == S_TERM && mdone) begin
      d_q[td] <= tneg ? d_q[td] - 34'(tr) : d_q[td] + 34'(tr);
      if (idx_q == 4'd11) begin
        for (int i = 0; i < 3; i++) qn_q[i] <= qsum[i];
        qn_q[3] <= (35'(att_q[3]) + 35'(d_q[3]) + 35'(tneg ? -tr : tr)
                    > 35'sd2147483647) ? 32'h7fff_ffff :
                   (35'(att_q[3]) + 35'(d_q[3]) + 35'(tneg ? -tr : tr)
                    < -35'sd2147483648) ? 32'h8000_0000 :
                   32'(35'(att_q[3]) + 35'(d_q[3]) + 35'(tneg ? -tr : tr));
      end
    end
    if (state_q == S_SQR && mdone) n2_q <= n2_q + 64'(prod);
    if (state_q == S_ROOT && sdone) nrm_q <= root;
    if (state_q == S_DIV && ddone) begin
      qn_q[idx_q[1:0]] <= qn_q[idx_q[1:0]][31] ?
        ((qv == 33'h1_0000_0000) ? 32'h8000_0000 : 32'(-$signed({1'b0, qv}))) :
        ((qv[32] || qv[31]) ? 32'h7fff_ffff : qv[31:0]);
    end
    if (out_fire) begin
      out_deg_q <= (n2_q == '0);
      out_data_q <= (n2_q == '0) ? {96'd0, OneQ30} :
                    {qn_q[3], qn_q[2], qn_q[1], qn_q[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_deg_q;
endmodule
